// ===== rtl/pav_pkg.sv =====
package pav_pkg;

  localparam int MAX_KEYS     = 512;
  localparam int KEY_IW       = $clog2(MAX_KEYS);
  localparam int NUM_SWITCHES = 16;
  localparam int SW_W         = $clog2(NUM_SWITCHES);
  localparam int KEY_AW       = SW_W + KEY_IW;
  localparam int NUM_FLOWS    = 256;
  localparam int FLOW_W       = $clog2(NUM_FLOWS);
  localparam int MAX_HOPS     = 8;
  localparam int HOP_IW       = $clog2(MAX_HOPS);
  localparam int HOP_CW       = HOP_IW + 1;
  localparam int PATH_AW      = FLOW_W + HOP_IW;
  localparam int CNT_W        = 10;

  localparam logic [31:0] LFSR_MASK  = 32'hB4BC_D35C;
  localparam logic [31:0] ADD_MASK   = 32'h07FF_FFFF;
  localparam logic [31:0] SKEW_RESET = 32'd30000;

  typedef enum logic [1:0] {
    CMD_LOAD_KEY = 2'd0,
    CMD_SETUP_SW = 2'd1,
    CMD_PATH_HOP = 2'd2,
    CMD_VERIFY   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_LOADED   = 3'd0,
    ST_ACCEPT   = 3'd1,
    ST_STALE    = 3'd2,
    ST_REPLAY   = 3'd3,
    ST_NO_PATH  = 3'd4,
    ST_UNKNOWN  = 3'd5,
    ST_MISMATCH = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_ROT_KA = 3'd1,
    OP_ROT_AK = 3'd2,
    OP_AND    = 3'd3,
    OP_OR     = 3'd4,
    OP_SUB_KA = 3'd5,
    OP_SUB_AK = 3'd6,
    OP_XOR    = 3'd7
  } op_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  switch_sel;
    logic [8:0]  entry_index;
    logic [31:0] word;
    logic [2:0]  op_code;
    logic [9:0]  count;
    logic [7:0]  flow_sel;
    logic [63:0] seq_number;
    logic [63:0] stamp_ms;
    logic [63:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] expected_acc;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [31:0]      value;
    logic [CNT_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [KEY_IW-1:0] rem;
  } mod_rsp_t;

endpackage

// ===== rtl/pav_mod_unit.sv =====
module pav_mod_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  pav_pkg::mod_req_t req,
  output pav_pkg::mod_rsp_t rsp
);
  import pav_pkg::*;

  // Restoring remainder, one dividend bit per cycle.
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [31:0]      val_r, val_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] div_r, div_nxt;
  logic [CNT_W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    val_nxt  = val_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    trial    = {rem_r, val_r[31]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd31;
      val_nxt  = req.value;
      rem_nxt  = '0;
      div_nxt  = req.divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = CNT_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[CNT_W-1:0];
      end
      val_nxt = {val_r[30:0], 1'b0};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    val_r <= val_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  // A zero key count selects index zero.
  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.rem  = (div_r == '0) ? '0 : rem_r[KEY_IW-1:0];

endmodule

// ===== rtl/pav_alu.sv =====
module pav_alu (
  input  logic [2:0]  op,
  input  logic [31:0] key,
  input  logic [31:0] acc,
  output logic [31:0] result
);
  import pav_pkg::*;

  logic [31:0] rx, ry, rot;
  logic [63:0] dbl;

  // Rotate-add: rx rotated left by ry[31:27], then ry[26:0] added.
  always_comb begin
    if (op_t'(op) == OP_ROT_KA) begin
      rx = key;
      ry = acc;
    end else begin
      rx = acc;
      ry = key;
    end
    dbl = {rx, rx} << ry[31:27];
    rot = dbl[63:32] + (ry & ADD_MASK);
  end

  always_comb begin
    case (op_t'(op))
      OP_ADD:    result = acc + key;
      OP_ROT_KA: result = rot;
      OP_ROT_AK: result = rot;
      OP_AND:    result = acc & key;
      OP_OR:     result = acc | key;
      OP_SUB_KA: result = key - acc;
      OP_SUB_AK: result = acc - key;
      OP_XOR:    result = acc ^ key;
      default:   result = acc ^ key;
    endcase
  end

endmodule

// ===== rtl/path_accumulator_verifier_unit.sv =====
// Path accumulator verifier.
// Input channel (in_valid/in_ready/in_data) takes one command item at a time:
// key load, switch setup, path hop write or verify. Every item yields exactly
// one result item on the output channel (out_valid/out_ready/out_data).
// Load, setup and path hop items pass through the decode and response
// states. A verify does the time window and sequence checks, then the hop,
// switch and ALU states per hop, plus a wait whenever a switch position needs
// a remainder by its key count from the shared bit-serial remainder unit.
// The block takes no new item until the current one is done, but
// a finished result waits in the output register while the next item is
// accepted; if the receiver stalls, the following result waits until the
// output register frees.
// Reset clears switch and flow control state, sets the skew window to 30000
// ms and empties the output register. Key, opcode and path memories are not
// cleared; they hold garbage until written. The configuration channel is
// always ready and should only be written while the block is idle.
module path_accumulator_verifier_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pav_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pav_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);
  import pav_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_DECODE = 10'b00_0000_0010,
    S_TABS   = 10'b00_0000_0100,
    S_TCMP   = 10'b00_0000_1000,
    S_SEQ    = 10'b00_0001_0000,
    S_HOP    = 10'b00_0010_0000,
    S_HOPSW  = 10'b00_0100_0000,
    S_ALU    = 10'b00_1000_0000,
    S_MOD    = 10'b01_0000_0000,
    S_RESP   = 10'b10_0000_0000
  } state_t;

  state_t    state_r;
  in_item_t  item_r;
  logic [31:0] win_r;
  logic [64:0] diff_r;
  logic [31:0] acc_r;
  logic [HOP_CW-1:0] hop_r;
  logic [HOP_CW-1:0] hop_lim_r;
  logic [SW_W-1:0]   sw_r;
  out_item_t res_r;
  out_item_t out_data_r;
  logic      out_valid_r;

  // Per-switch walk state, small enough for flip-flops.
  logic [CNT_W-1:0]  sw_count_r [NUM_SWITCHES];
  logic [31:0]       sw_seed_r  [NUM_SWITCHES];
  logic [31:0]       sw_lfsr_r  [NUM_SWITCHES];
  logic [KEY_IW-1:0] sw_index_r [NUM_SWITCHES];
  logic [NUM_SWITCHES-1:0] sw_seqmode_r;
  logic [NUM_SWITCHES-1:0] sw_present_r;

  // Per-flow valid bits; the matching data sits in memories.
  logic [NUM_FLOWS-1:0] flow_seen_r;
  logic [NUM_FLOWS-1:0] flow_present_r;

  // Memories with registered reads.
  logic [34:0]       key_mem  [2**KEY_AW];
  logic [SW_W-1:0]   path_mem [2**PATH_AW];
  logic [63:0]       seq_mem  [NUM_FLOWS];
  logic [HOP_CW-1:0] len_mem  [NUM_FLOWS];
  logic [34:0]       key_q;
  logic [SW_W-1:0]   path_q;
  logic [63:0]       seq_q;
  logic [HOP_CW-1:0] len_q;

  mod_req_t    mod_req;
  mod_rsp_t    mod_rsp;
  logic [31:0] alu_res;

  logic              in_fire;
  logic              key_we, path_we, len_we, seq_we;
  logic              key_re, path_re, flow_re;
  logic [KEY_AW-1:0] key_raddr;
  logic              stale;
  logic              replay;
  logic [HOP_CW-1:0] lim_nxt;
  logic [CNT_W-1:0]  idx_inc;
  logic [31:0]       lfsr_step;
  logic [CNT_W-1:0]  sat_keys;
  logic [HOP_CW-1:0] sat_hops;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign key_we  = (state_r == S_DECODE) && (cmd_t'(item_r.cmd) == CMD_LOAD_KEY);
  assign path_we = (state_r == S_DECODE) && (cmd_t'(item_r.cmd) == CMD_PATH_HOP)
                   && (32'(item_r.entry_index) < MAX_HOPS);
  assign len_we  = (state_r == S_DECODE) && (cmd_t'(item_r.cmd) == CMD_PATH_HOP);
  assign stale   = (diff_r[63:32] != '0) || (diff_r[31:0] > win_r);
  assign flow_re = (state_r == S_TCMP) && !stale;
  assign replay  = flow_seen_r[item_r.flow_sel] && (item_r.seq_number <= seq_q);
  assign seq_we  = (state_r == S_SEQ) && !replay;
  assign path_re = (state_r == S_HOP);
  assign key_re  = (state_r == S_HOPSW);
  assign key_raddr = {path_q, sw_index_r[path_q]};

  assign sat_keys = (32'(item_r.count) > MAX_KEYS) ? CNT_W'(MAX_KEYS) : item_r.count;
  assign sat_hops = (32'(item_r.count) > MAX_HOPS) ? HOP_CW'(MAX_HOPS)
                                                   : item_r.count[HOP_CW-1:0];
  assign lim_nxt  = (item_r.count < CNT_W'(len_q)) ? item_r.count[HOP_CW-1:0] : len_q;
  assign idx_inc  = CNT_W'(sw_index_r[sw_r]) + CNT_W'(1);
  assign lfsr_step = sw_lfsr_r[sw_r][0] ? ((sw_lfsr_r[sw_r] >> 1) ^ LFSR_MASK)
                                        : (sw_lfsr_r[sw_r] >> 1);

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[{item_r.switch_sel, item_r.entry_index}] <= {item_r.op_code, item_r.word};
    end
    if (key_re) begin
      key_q <= key_mem[key_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (path_we) begin
      path_mem[{item_r.flow_sel, item_r.entry_index[HOP_IW-1:0]}] <= item_r.switch_sel;
    end
    if (path_re) begin
      path_q <= path_mem[{item_r.flow_sel, hop_r[HOP_IW-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (seq_we) begin
      seq_mem[item_r.flow_sel] <= item_r.seq_number;
    end
    if (len_we) begin
      len_mem[item_r.flow_sel] <= sat_hops;
    end
    if (flow_re) begin
      seq_q <= seq_mem[item_r.flow_sel];
      len_q <= len_mem[item_r.flow_sel];
    end
  end

  // The remainder unit is started whenever a switch leaves its ordered walk or
  // follows its LFSR walk; the walk restarts from the seed after the last ordered key.
  always_comb begin
    mod_req.start   = 1'b0;
    mod_req.value   = lfsr_step;
    mod_req.divisor = sw_count_r[sw_r];
    if (state_r == S_ALU) begin
      if (sw_seqmode_r[sw_r]) begin
        mod_req.start = (idx_inc >= sw_count_r[sw_r]);
        mod_req.value = sw_seed_r[sw_r];
      end else begin
        mod_req.start = 1'b1;
      end
    end
  end

  pav_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  pav_alu u_alu (
    .op     (key_q[34:32]),
    .key    (key_q[31:0]),
    .acc    (acc_r),
    .result (alu_res)
  );

  // Switch walk state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SWITCHES; i++) begin
        sw_count_r[i] <= '0;
        sw_seed_r[i]  <= '0;
        sw_lfsr_r[i]  <= '0;
        sw_index_r[i] <= '0;
      end
      sw_seqmode_r <= '1;
      sw_present_r <= '0;
    end else if ((state_r == S_DECODE) && (cmd_t'(item_r.cmd) == CMD_SETUP_SW)) begin
      sw_count_r[item_r.switch_sel]   <= sat_keys;
      sw_seed_r[item_r.switch_sel]    <= item_r.word;
      sw_lfsr_r[item_r.switch_sel]    <= item_r.word;
      sw_index_r[item_r.switch_sel]   <= '0;
      sw_seqmode_r[item_r.switch_sel] <= 1'b1;
      sw_present_r[item_r.switch_sel] <= 1'b1;
    end else if (state_r == S_ALU) begin
      if (sw_seqmode_r[sw_r]) begin
        if (idx_inc >= sw_count_r[sw_r]) begin
          sw_seqmode_r[sw_r] <= 1'b0;
          sw_lfsr_r[sw_r]    <= sw_seed_r[sw_r];
        end else begin
          sw_index_r[sw_r] <= idx_inc[KEY_IW-1:0];
        end
      end else begin
        sw_lfsr_r[sw_r] <= lfsr_step;
      end
    end else if ((state_r == S_MOD) && mod_rsp.done) begin
      sw_index_r[sw_r] <= mod_rsp.rem;
    end
  end

  // Flow valid bits and the configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flow_seen_r    <= '0;
      flow_present_r <= '0;
      win_r          <= SKEW_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        win_r <= cfg_data;
      end
      if (seq_we) begin
        flow_seen_r[item_r.flow_sel] <= 1'b1;
      end
      if (len_we) begin
        flow_present_r[item_r.flow_sel] <= 1'b1;
      end
    end
  end

  // Main sequencer. The output register is cleared on a taken result unless
  // the response state refills it in the same cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      hop_r       <= '0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_RESP)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            item_r  <= in_data;
            state_r <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_r.status       <= ST_LOADED;
          res_r.expected_acc <= '0;
          diff_r  <= {1'b0, item_r.now_ms} - {1'b0, item_r.stamp_ms};
          state_r <= (cmd_t'(item_r.cmd) == CMD_VERIFY) ? S_TABS : S_RESP;
        end
        S_TABS: begin
          if (diff_r[64]) begin
            diff_r <= {1'b0, ~diff_r[63:0] + 64'd1};
          end
          state_r <= S_TCMP;
        end
        S_TCMP: begin
          if (stale) begin
            res_r.status <= ST_STALE;
            state_r      <= S_RESP;
          end else begin
            state_r <= S_SEQ;
          end
        end
        S_SEQ: begin
          acc_r     <= '0;
          hop_r     <= '0;
          hop_lim_r <= lim_nxt;
          if (replay) begin
            res_r.status <= ST_REPLAY;
            state_r      <= S_RESP;
          end else if (!flow_present_r[item_r.flow_sel]) begin
            res_r.status <= ST_NO_PATH;
            state_r      <= S_RESP;
          end else begin
            state_r <= S_HOP;
          end
        end
        S_HOP: begin
          if (hop_r >= hop_lim_r) begin
            res_r.status       <= (acc_r == item_r.word) ? ST_ACCEPT : ST_MISMATCH;
            res_r.expected_acc <= acc_r;
            state_r            <= S_RESP;
          end else begin
            state_r <= S_HOPSW;
          end
        end
        S_HOPSW: begin
          sw_r <= path_q;
          if (!sw_present_r[path_q]) begin
            res_r.status <= ST_UNKNOWN;
            state_r      <= S_RESP;
          end else begin
            state_r <= S_ALU;
          end
        end
        S_ALU: begin
          acc_r <= alu_res;
          if (mod_req.start) begin
            state_r <= S_MOD;
          end else begin
            hop_r   <= hop_r + HOP_CW'(1);
            state_r <= S_HOP;
          end
        end
        S_MOD: begin
          if (mod_rsp.done) begin
            hop_r   <= hop_r + HOP_CW'(1);
            state_r <= S_HOP;
          end
        end
        S_RESP: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // The remainder unit only finishes while the sequencer waits for it.
  a_mod_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mod_rsp.done |-> (state_r == S_MOD))
    else $error("remainder finished outside its wait state");

  // No new item is taken while the remainder unit is still working.
  a_idle_mod_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !mod_rsp.busy)
    else $error("item accepted while remainder unit busy");

  // The hop counter never walks past the longest path.
  a_hop_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(hop_r) <= MAX_HOPS))
    else $error("hop counter beyond path limit");

  // An accepted item is decoded in the next cycle.
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_DECODE))
    else $error("accepted item not decoded");
`endif

endmodule

// ===== dv/testbench.sv =====
module testbench;
  import pav_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int TAIL_CYCLES = 400;
  localparam int CHUNK_ITEMS = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;

  path_accumulator_verifier_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of everything the block keeps: key tables per switch, the
  // switch walk positions, and per-flow sequence and path records. The
  // "set" bits track which memory entries were written, so that the stimulus
  // never makes the block read memory that still holds garbage.
  logic [31:0] key_mem [NUM_SWITCHES][MAX_KEYS];
  logic [2:0]  op_mem  [NUM_SWITCHES][MAX_KEYS];
  bit          key_set [NUM_SWITCHES][MAX_KEYS];
  int          sw_count [NUM_SWITCHES];
  logic [31:0] sw_seed  [NUM_SWITCHES];
  logic [31:0] sw_lfsr  [NUM_SWITCHES];
  int          sw_idx   [NUM_SWITCHES];
  bit          sw_seq   [NUM_SWITCHES];
  bit          sw_on    [NUM_SWITCHES];
  logic [63:0] fl_last  [NUM_FLOWS];
  bit          fl_seen  [NUM_FLOWS];
  int          fl_len   [NUM_FLOWS];
  bit          fl_on    [NUM_FLOWS];
  logic [3:0]  hop_sw   [NUM_FLOWS][MAX_HOPS];
  bit          hop_set  [NUM_FLOWS][MAX_HOPS];
  logic [31:0] skew = SKEW_RESET;

  // Verdicts the block still owes us, oldest first.
  out_item_t verdict_q[$];
  int errors = 0;
  int sent = 0;
  int cycles = 0;
  bit idle_en = 1'b1;

  typedef struct {
    in_item_t  it;
    bit        fill_word;
    bit        typed;
    out_item_t want;
  } row_t;

  row_t rows[$];

  task automatic note(string msg);
    if (errors < 10) $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic logic [31:0] rot_add(logic [31:0] x, logic [31:0] y);
    logic [4:0] amt;
    logic [31:0] r;
    amt = y[31:27];
    r = (amt == 5'd0) ? x : ((x << amt) | (x >> (32 - amt)));
    return r + (y & ADD_MASK);
  endfunction

  function automatic logic [31:0] hop_result(op_t op, logic [31:0] k, logic [31:0] a);
    case (op)
      OP_ADD:    return a + k;
      OP_ROT_KA: return rot_add(k, a);
      OP_ROT_AK: return rot_add(a, k);
      OP_AND:    return a & k;
      OP_OR:     return a | k;
      OP_SUB_KA: return k - a;
      OP_SUB_AK: return a - k;
      default:   return a ^ k;
    endcase
  endfunction

  function automatic int wrap_index(logic [31:0] v, int n);
    return (n == 0) ? 0 : int'(v % 32'(n));
  endfunction

  // Works out the verdict for one item. With commit clear it is a dry run:
  // the stimulus uses it to learn the accumulator a verify will replay.
  function automatic out_item_t judge_item(in_item_t it, bit commit);
    out_item_t r;
    logic [63:0] diff;
    logic [31:0] acc;
    logic [31:0] lf [NUM_SWITCHES];
    int ix [NUM_SWITCHES];
    bit sq [NUM_SWITCHES];
    int hops, s, slot, n;
    bit unknown;
    r.status = ST_LOADED;
    r.expected_acc = '0;
    case (cmd_t'(it.cmd))
      CMD_LOAD_KEY: begin
        if (commit) begin
          key_mem[it.switch_sel][it.entry_index] = it.word;
          op_mem[it.switch_sel][it.entry_index] = it.op_code;
          key_set[it.switch_sel][it.entry_index] = 1'b1;
        end
      end
      CMD_SETUP_SW: begin
        if (commit) begin
          n = (it.count > MAX_KEYS) ? MAX_KEYS : int'(it.count);
          sw_count[it.switch_sel] = n;
          sw_seed[it.switch_sel] = it.word;
          sw_lfsr[it.switch_sel] = it.word;
          sw_idx[it.switch_sel] = 0;
          sw_seq[it.switch_sel] = 1'b1;
          sw_on[it.switch_sel] = 1'b1;
        end
      end
      CMD_PATH_HOP: begin
        if (commit) begin
          if (it.entry_index < MAX_HOPS) begin
            hop_sw[it.flow_sel][it.entry_index] = it.switch_sel;
            hop_set[it.flow_sel][it.entry_index] = 1'b1;
          end
          fl_len[it.flow_sel] = (it.count > MAX_HOPS) ? MAX_HOPS : int'(it.count);
          fl_on[it.flow_sel] = 1'b1;
        end
      end
      default: begin
        diff = (it.now_ms > it.stamp_ms) ? it.now_ms - it.stamp_ms : it.stamp_ms - it.now_ms;
        if (diff > {32'd0, skew}) begin
          r.status = ST_STALE;
        end else if (fl_seen[it.flow_sel] && it.seq_number <= fl_last[it.flow_sel]) begin
          r.status = ST_REPLAY;
        end else begin
          // The sequence number sticks even when the replay later fails.
          if (commit) begin
            fl_last[it.flow_sel] = it.seq_number;
            fl_seen[it.flow_sel] = 1'b1;
          end
          if (!fl_on[it.flow_sel]) begin
            r.status = ST_NO_PATH;
          end else begin
            lf = sw_lfsr;
            ix = sw_idx;
            sq = sw_seq;
            acc = '0;
            unknown = 1'b0;
            hops = (int'(it.count) < fl_len[it.flow_sel]) ? int'(it.count)
                                                          : fl_len[it.flow_sel];
            for (int h = 0; h < hops; h++) begin
              s = hop_sw[it.flow_sel][h];
              if (!sw_on[s]) begin
                unknown = 1'b1;
                break;
              end
              slot = ix[s] % MAX_KEYS;
              acc = hop_result(op_t'(op_mem[s][slot]), key_mem[s][slot], acc);
              // Walk in key order first, then hand over to the LFSR.
              if (sq[s]) begin
                ix[s]++;
                if (ix[s] >= sw_count[s]) begin
                  sq[s] = 1'b0;
                  lf[s] = sw_seed[s];
                  ix[s] = wrap_index(lf[s], sw_count[s]);
                end
              end else begin
                lf[s] = lf[s][0] ? ((lf[s] >> 1) ^ LFSR_MASK) : (lf[s] >> 1);
                ix[s] = wrap_index(lf[s], sw_count[s]);
              end
            end
            if (unknown) begin
              r.status = ST_UNKNOWN;
            end else begin
              r.expected_acc = acc;
              r.status = (acc == it.word) ? ST_ACCEPT : ST_MISMATCH;
            end
            if (commit) begin
              sw_lfsr = lf;
              sw_idx = ix;
              sw_seq = sq;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  // Largest hop limit up to want that never reads an unwritten hop entry.
  // A hop on an absent switch ends the replay, so nothing past it matters.
  function automatic int safe_hops(int f, int want);
    for (int h = 0; h < want && h < fl_len[f]; h++) begin
      if (!hop_set[f][h]) return h;
      if (!sw_on[hop_sw[f][h]]) return want;
    end
    return want;
  endfunction

  function automatic int key_prefix(int s);
    for (int i = 0; i < MAX_KEYS; i++)
      if (!key_set[s][i]) return i;
    return MAX_KEYS;
  endfunction

  function automatic in_item_t noise_item();
    in_item_t it;
    it.cmd = 2'($urandom);
    it.switch_sel = 4'($urandom);
    it.entry_index = 9'($urandom);
    it.word = $urandom;
    it.op_code = 3'($urandom);
    it.count = 10'($urandom);
    it.flow_sel = 8'($urandom);
    it.seq_number = {$urandom, $urandom};
    it.stamp_ms = {$urandom, $urandom};
    it.now_ms = {$urandom, $urandom};
    return it;
  endfunction

  function automatic in_item_t mk(cmd_t c, int sw, int ent, logic [31:0] w, op_t op,
                                  int cnt, int fl, logic [63:0] seq, logic [63:0] stamp,
                                  logic [63:0] now);
    in_item_t it;
    it.cmd = c;
    it.switch_sel = 4'(sw);
    it.entry_index = 9'(ent);
    it.word = w;
    it.op_code = op;
    it.count = 10'(cnt);
    it.flow_sel = 8'(fl);
    it.seq_number = seq;
    it.stamp_ms = stamp;
    it.now_ms = now;
    return it;
  endfunction

  // Presents one item and holds it until the block takes it. The valid line
  // only drops when the sender decides to idle, so back-to-back items never
  // see a low and a high scheduled in the same step.
  task automatic send(in_item_t it, bit typed, out_item_t want);
    out_item_t got;
    while (idle_en && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = judge_item(it, 1'b1);
    verdict_q.insert(verdict_q.size(), typed ? want : got);
    sent++;
  endtask

  task automatic send_item(in_item_t it);
    send(it, 1'b0, '0);
  endtask

  // Register writes only happen with the block drained and quiet.
  task automatic set_window(logic [31:0] v);
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    skew = v;
  endtask

  task automatic load_key(int s, int slot);
    in_item_t it;
    it = noise_item();
    it.cmd = CMD_LOAD_KEY;
    it.switch_sel = 4'(s);
    it.entry_index = 9'(slot);
    send_item(it);
  endtask

  // Switch setup: small key counts are preceded by loads of any missing key
  // slots; larger counts are cut to at most the leading run of loaded slots.
  task automatic setup_action();
    in_item_t it;
    int s, n, p, need;
    s = ($urandom_range(99) < 85) ? $urandom_range(7) : $urandom_range(15);
    if ($urandom_range(99) < 85) n = $urandom_range(1, 8);
    else if ($urandom_range(1) == 0) n = 0;
    else n = $urandom_range(1023);
    need = (n > MAX_KEYS) ? MAX_KEYS : n;
    if (need == 0) need = 1;
    if (need <= 16) begin
      for (int i = 0; i < need; i++)
        if (!key_set[s][i]) load_key(s, i);
    end else if (!key_set[s][0]) begin
      load_key(s, 0);
    end
    p = key_prefix(s);
    if (need > p) n = $urandom_range(p, 0);
    it = noise_item();
    it.cmd = CMD_SETUP_SW;
    it.switch_sel = 4'(s);
    it.count = 10'(n);
    if ($urandom_range(9) == 0) it.word = '0;
    send_item(it);
  endtask

  task automatic path_action();
    in_item_t it;
    int f, len;
    f = ($urandom_range(99) < 80) ? $urandom_range(7) : $urandom_range(255);
    len = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(1023);
    if ($urandom_range(99) < 70) begin
      for (int h = 0; h < len && h < MAX_HOPS; h++) begin
        it = noise_item();
        it.cmd = CMD_PATH_HOP;
        it.flow_sel = 8'(f);
        it.entry_index = 9'(h);
        it.count = 10'(len);
        it.switch_sel = ($urandom_range(99) < 90) ? 4'($urandom_range(7)) : 4'($urandom);
        send_item(it);
      end
    end else begin
      it = noise_item();
      it.cmd = CMD_PATH_HOP;
      it.flow_sel = 8'(f);
      it.count = 10'(len);
      if ($urandom_range(1) == 0) it.entry_index = 9'($urandom_range(MAX_HOPS - 1));
      send_item(it);
    end
  endtask

  task automatic verify_action();
    in_item_t it;
    out_item_t dry;
    int f, k, lim;
    logic [63:0] delta;
    it = noise_item();
    it.cmd = CMD_VERIFY;
    f = ($urandom_range(99) < 85) ? $urandom_range(7) : $urandom_range(255);
    it.flow_sel = 8'(f);
    k = $urandom_range(99);
    if (fl_seen[f] && k < 80) it.seq_number = fl_last[f] + 64'($urandom_range(1, 1000));
    else if (fl_seen[f] && k < 90) it.seq_number = fl_last[f];
    // Mostly inside the window, with both edges of it and wild stamps.
    k = $urandom_range(9);
    if (k < 7) delta = 64'($urandom_range(skew, 0));
    else if (k == 7) delta = {32'd0, skew};
    else delta = {32'd0, skew} + 64'd1;
    if (k < 9) it.stamp_ms = ($urandom_range(1) == 0) ? it.now_ms + delta : it.now_ms - delta;
    k = $urandom_range(99);
    if (k < 60) lim = MAX_HOPS;
    else if (k < 90) lim = $urandom_range(9);
    else lim = $urandom_range(1023);
    it.count = 10'(safe_hops(f, lim));
    if ($urandom_range(99) < 80) begin
      dry = judge_item(it, 1'b0);
      it.word = dry.expected_acc;
    end
    send_item(it);
  endtask

  task automatic random_action();
    int r;
    r = $urandom_range(99);
    if (r < 10) load_key($urandom_range(15), $urandom_range(MAX_KEYS - 1));
    else if (r < 18) setup_action();
    else if (r < 35) path_action();
    else verify_action();
  endtask

  // Receiver: checks each result against the oldest verdict and stalls at
  // random, except during the stretch where idling is switched off.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          note($sformatf("unexpected result status %0d acc %h",
                         out_data.status, out_data.expected_acc));
        end else begin
          want = verdict_q.pop_front();
          if (out_data.status !== want.status)
            note($sformatf("status expected %0d got %0d", want.status, out_data.status));
          if (out_data.expected_acc !== want.expected_acc)
            note($sformatf("acc expected %h got %h", want.expected_acc,
                           out_data.expected_acc));
        end
      end
      out_ready <= idle_en ? ($urandom_range(99) >= 17) : 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [31:0] windows [4];
    out_item_t loaded;
    int goal;
    loaded = '{status: ST_LOADED, expected_acc: 32'd0};
    for (int s = 0; s < NUM_SWITCHES; s++) begin
      sw_count[s] = 0;
      sw_seed[s] = '0;
      sw_lfsr[s] = '0;
      sw_idx[s] = 0;
      sw_seq[s] = 1'b1;
      sw_on[s] = 1'b0;
    end
    for (int f = 0; f < NUM_FLOWS; f++) begin
      fl_last[f] = '0;
      fl_seen[f] = 1'b0;
      fl_len[f] = 0;
      fl_on[f] = 1'b0;
    end

    // Directed items. Early verifies run against the reset window: no path
    // yet, a replayed sequence number, both window edges and the widest gap.
    rows.insert(rows.size(), '{mk(CMD_VERIFY, 0, 0, 0, OP_ADD, 8, 0, 0, 0, 0), 0, 1,
                               '{ST_NO_PATH, 32'd0}});
    rows.insert(rows.size(), '{mk(CMD_VERIFY, 0, 0, 0, OP_ADD, 8, 0, 0, 0, 0), 0, 1,
                               '{ST_REPLAY, 32'd0}});
    rows.insert(rows.size(), '{mk(CMD_VERIFY, 0, 0, 0, OP_ADD, 8, 1, 5, 30001, 0), 0, 1,
                               '{ST_STALE, 32'd0}});
    rows.insert(rows.size(), '{mk(CMD_VERIFY, 0, 0, 0, OP_ADD, 8, 1, '1, 0, 30000), 0, 1,
                               '{ST_NO_PATH, 32'd0}});
    rows.insert(rows.size(), '{mk(CMD_VERIFY, 0, 0, 0, OP_ADD, 8, 2, 1, 0, '1), 0, 1,
                               '{ST_STALE, 32'd0}});
    rows.insert(rows.size(), '{mk(CMD_LOAD_KEY, 0, 511, '1, OP_XOR, 0, 0, 0, 0, 0), 0, 1,
                               loaded});
    // One switch with a key per operation, walked by an eight hop path; the
    // first verify pushes the walk over into LFSR mode and the second runs in it.
    for (int i = 0; i < 8; i++)
      rows.insert(rows.size(),
                  '{mk(CMD_LOAD_KEY, 0, i, 32'h9E37_79B9 * (i + 1) + 32'hF800_0000 * i,
                       op_t'(i), 0, 0, 0, 0, 0), 0, 1, loaded});
    rows.insert(rows.size(), '{mk(CMD_SETUP_SW, 0, 0, '1, OP_ADD, 8, 0, 0, 0, 0), 0, 1,
                               loaded});
    for (int h = 0; h < 8; h++)
      rows.insert(rows.size(),
                  '{mk(CMD_PATH_HOP, 0, h, 0, OP_ADD, (h == 7) ? 1023 : 8, 5, 0, 0, 0),
                    0, 1, loaded});
    rows.insert(rows.size(), '{mk(CMD_VERIFY, 0, 0, 0, OP_ADD, 8, 5, 1, '1, '1), 1, 0, '0});
    rows.insert(rows.size(), '{mk(CMD_VERIFY, 0, 0, 0, OP_ADD, 8, 5, 2, '1, '1), 0, 0, '0});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      out_item_t dry;
      if (rows[i].fill_word) begin
        dry = judge_item(rows[i].it, 1'b0);
        rows[i].it.word = dry.expected_acc;
      end
      send(rows[i].it, rows[i].typed, rows[i].want);
    end

    // Fill every slot of one switch so that a saturated key count is safe.
    set_window(32'hFFFF_FFFF);
    for (int i = 0; i < MAX_KEYS; i++) load_key(15, i);
    send_item(mk(CMD_SETUP_SW, 15, 0, $urandom, OP_ADD, 1023, 0, 0, 0, 0));

    windows[0] = 32'd0;
    windows[1] = 32'hFFFF_FFFF;
    windows[2] = $urandom;
    windows[3] = SKEW_RESET;
    for (int c = 0; c < 4; c++) begin
      // Each phase starts drained, which also covers the sender waiting for
      // every outstanding result.
      set_window(windows[c]);
      idle_en = (c != 1);
      goal = sent + CHUNK_ITEMS;
      while (sent < goal) random_action();
    end
    idle_en = 1'b1;

    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (verdict_q.size() != 0) note("results still outstanding at the end");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
